### hw/rtl/affine_range_update_sum_tree_defines.svh
// assertion macros used by the checker file
`ifndef AFFINE_RANGE_UPDATE_SUM_TREE_DEFINES_SVH
`define AFFINE_RANGE_UPDATE_SUM_TREE_DEFINES_SVH

// clocked assertion, disabled while reset is low
`define ARUT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ARUT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/arut_pkg.sv
// ----------------------------------------------------------------------------
// arut_pkg
// shared types and constants of the range-affine / range-sum tree
// ----------------------------------------------------------------------------
`default_nettype none

package arut_pkg;

  // opcodes of an input transaction
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // one tree node: sum plus pending affine tag
  typedef struct packed {
    logic [63:0] sum;
    logic [63:0] mult;
    logic [63:0] add;
  } entry_t;

  localparam entry_t ENTRY_CLEAR = '{sum: 64'd0, mult: 64'd1, add: 64'd0};

  // walk frame phase
  typedef enum logic [1:0] {
    PH_ENTER = 2'd0,
    PH_RIGHT = 2'd1,
    PH_CLOSE = 2'd2
  } phase_e;

  // shared multiplier request and response
  typedef struct packed {
    logic        start;
    logic [63:0] x;
    logic [63:0] y;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/affine_range_update_sum_tree.sv
// walk: an item walks the tree frame by frame; a node with a pending tag costs six 64-bit
//   products (two at a leaf) on the one shared 32x32 multiplier, plus child reads and writes
//   on the single node-store port
// items: one at a time; a new item is taken only while the block is idle;
//   a query result is registered when its walk ends and holds off the next result
// reset and every size write start a clearing pass over all 4*MAX_ELEMENTS nodes, no items taken
// ----------------------------------------------------------------------------
// affine_range_update_sum_tree
// lazy segment tree with range affine update and range sum query
// ----------------------------------------------------------------------------
`default_nettype none

module affine_range_update_sum_tree #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [10:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               opcode_i,
  input  wire logic [9:0]         left_index_i,
  input  wire logic [9:0]         right_index_i,
  input  wire logic signed [63:0] mult_factor_i,
  input  wire logic signed [63:0] add_term_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [63:0]      range_sum_o
);

  localparam int unsigned NodeCnt = 4 * MAX_ELEMENTS;
  localparam int unsigned NodeAw  = $clog2(NodeCnt);

  logic               mem_we;
  logic [NodeAw-1:0]  mem_addr;
  arut_pkg::entry_t   mem_wdata, mem_rdata;
  arut_pkg::mul_req_t mul_req;
  arut_pkg::mul_rsp_t mul_rsp;
  logic [63:0]        out_sum;

  // walk sequencer
  arut_ctrl #(.MaxElements(MAX_ELEMENTS)) u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .opcode_i,
    .left_index_i,
    .right_index_i,
    .mult_factor_i (64'(mult_factor_i)),
    .add_term_i    (64'(add_term_i)),
    .out_valid_o,
    .out_ready_i,
    .out_sum_o     (out_sum),
    .mem_we_o      (mem_we),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .mem_rdata_i   (mem_rdata),
    .mul_req_o     (mul_req),
    .mul_rsp_i     (mul_rsp)
  );

  // node store
  arut_node_ram #(.Depth(NodeCnt)) u_ram (
    .clk_i,
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // shared multiplier
  arut_mul u_mul (
    .clk_i,
    .rst_ni,
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  assign range_sum_o = signed'(out_sum);

endmodule

`default_nettype wire

### hw/rtl/arut_mul.sv
// ----------------------------------------------------------------------------
// arut_mul
// 64x64 wrapping multiplier built from one 32x32 multiplier, low-low, high-low and low-high products in turn
// ----------------------------------------------------------------------------
`default_nettype none

module arut_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire arut_pkg::mul_req_t req_i,
  output arut_pkg::mul_rsp_t     rsp_o
);

  typedef enum logic [4:0] {
    MS_IDLE = 5'b00001,
    MS_LL   = 5'b00010,
    MS_HL   = 5'b00100,
    MS_LH   = 5'b01000,
    MS_LAST = 5'b10000
  } mstate_e;

  mstate_e     state_q;
  logic        done_q;
  logic [63:0] x_q, y_q;
  logic [63:0] prod_q;
  logic [63:0] acc_q;
  logic [31:0] a_op, b_op;

  // operand select for the current partial product
  always_comb begin
    a_op = (state_q == MS_HL) ? x_q[63:32] : x_q[31:0];
    b_op = (state_q == MS_LH) ? y_q[63:32] : y_q[31:0];
  end

  // step sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MS_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        MS_IDLE: if (req_i.start) state_q <= MS_LL;
        MS_LL:   state_q <= MS_HL;
        MS_HL:   state_q <= MS_LH;
        MS_LH:   state_q <= MS_LAST;
        MS_LAST: begin
          state_q <= MS_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= MS_IDLE;
      endcase
    end
  end

  // partial products and accumulation
  always_ff @(posedge clk_i) begin
    if (state_q == MS_IDLE && req_i.start) begin
      x_q <= req_i.x;
      y_q <= req_i.y;
    end
    prod_q <= 64'(a_op) * 64'(b_op);
    unique case (state_q)
      MS_HL:   acc_q <= prod_q;
      MS_LH:   acc_q <= acc_q + {prod_q[31:0], 32'd0};
      MS_LAST: acc_q <= acc_q + {prod_q[31:0], 32'd0};
      default: acc_q <= acc_q;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule

`default_nettype wire

### hw/rtl/arut_node_ram.sv
// ----------------------------------------------------------------------------
// arut_node_ram
// single-port node store with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module arut_node_ram #(
  parameter  int unsigned Depth = 4096,
  localparam int unsigned Aw    = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    addr_i,
  input  wire arut_pkg::entry_t wdata_i,
  output arut_pkg::entry_t      rdata_o
);

  arut_pkg::entry_t mem_q [Depth];
  arut_pkg::entry_t rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/arut_ctrl.sv
// ----------------------------------------------------------------------------
// arut_ctrl
// walk sequencer: frame stack, node refresh, tag push-down and sum rebuild
// ----------------------------------------------------------------------------
`default_nettype none

module arut_ctrl #(
  parameter  int unsigned MaxElements = 1024,
  localparam int unsigned NodeCnt     = 4 * MaxElements,
  localparam int unsigned NodeAw      = $clog2(NodeCnt)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [10:0]         cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                opcode_i,
  input  wire logic [9:0]          left_index_i,
  input  wire logic [9:0]          right_index_i,
  input  wire logic [63:0]         mult_factor_i,
  input  wire logic [63:0]         add_term_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [63:0]              out_sum_o,
  output logic                     mem_we_o,
  output logic [NodeAw-1:0]        mem_addr_o,
  output arut_pkg::entry_t         mem_wdata_o,
  input  wire arut_pkg::entry_t    mem_rdata_i,
  output arut_pkg::mul_req_t       mul_req_o,
  input  wire arut_pkg::mul_rsp_t  mul_rsp_i
);

  localparam int unsigned IdxW     = $clog2(MaxElements);
  localparam int unsigned SzW      = $clog2(MaxElements + 1);
  localparam int unsigned StkAw    = $clog2($clog2(MaxElements) + 2);
  localparam int unsigned StkDepth = 2 ** StkAw;
  localparam int unsigned SizeRst  = (MaxElements < 1024) ? MaxElements : 1024;

  typedef struct packed {
    logic [NodeAw-1:0]  node;
    logic [IdxW-1:0]    lo;
    logic [IdxW-1:0]    hi;
    arut_pkg::phase_e   phase;
  } frame_t;

  typedef enum logic [15:0] {
    ST_CLR     = 16'h0001,
    ST_IDLE    = 16'h0002,
    ST_TOP     = 16'h0004,
    ST_RD_NODE = 16'h0008,
    ST_APPLY   = 16'h0010,
    ST_DECIDE  = 16'h0020,
    ST_CH_RD   = 16'h0040,
    ST_CH_GET  = 16'h0080,
    ST_CH_A    = 16'h0100,
    ST_CH_M    = 16'h0200,
    ST_ND_S    = 16'h0400,
    ST_ND_A    = 16'h0800,
    ST_ND_W    = 16'h1000,
    ST_MWAIT   = 16'h2000,
    ST_P2_L    = 16'h4000,
    ST_P2_R    = 16'h8000
  } state_e;

  state_e             state_q, state_d;
  state_e             mul_next_q;
  logic [StkAw:0]     sp_q;
  frame_t             stk_q [StkDepth];
  logic [NodeAw-1:0]  clr_q;
  logic [SzW-1:0]     size_q;
  logic               out_valid_q;
  logic [63:0]        out_sum_q;
  logic               is_query_q;
  logic [9:0]         ql_q, qr_q;
  logic [63:0]        m_q, a_q, acc_q;
  logic [63:0]        nd_sum_q, tm_q, ta_q;
  logic [63:0]        ch_sum_q, ch_mult_q, ch_add_q, tmp_q;
  logic               ch_sel_q;
  logic               ret_pop_q;

  logic [StkAw-1:0]   top_idx;
  logic [StkAw-1:0]   push_idx;
  frame_t             top_f;
  logic [IdxW:0]      mid_w;
  logic [IdxW-1:0]    mid;
  logic [IdxW:0]      len;
  logic [NodeAw-1:0]  lc, rc, ch_addr;
  logic               covered, disjoint, is_leaf, is_ident;
  logic               in_acc, fin_ok;
  logic [31:0]        cfg_ext, size_clamp;

  // top frame and its derived ranges
  always_comb begin
    top_idx  = StkAw'(sp_q - 1'b1);
    push_idx = sp_q[StkAw-1:0];
    top_f    = stk_q[top_idx];
    mid_w    = ({1'b0, top_f.lo} + {1'b0, top_f.hi}) >> 1;
    mid      = mid_w[IdxW-1:0];
    len      = {1'b0, top_f.hi} - {1'b0, top_f.lo} + 1'b1;
    lc       = NodeAw'({top_f.node, 1'b0}) + NodeAw'(1);
    rc       = NodeAw'({top_f.node, 1'b0}) + NodeAw'(2);
    ch_addr  = ch_sel_q ? rc : lc;
    covered  = (32'(ql_q) <= 32'(top_f.lo)) && (32'(top_f.hi) <= 32'(qr_q));
    disjoint = (32'(ql_q) > 32'(top_f.hi)) || (32'(top_f.lo) > 32'(qr_q));
    is_leaf  = (top_f.lo == top_f.hi);
    is_ident = (mem_rdata_i.mult == 64'd1) && (mem_rdata_i.add == 64'd0);
    in_acc   = in_valid_i && in_ready_o;
    fin_ok   = !out_valid_q || out_ready_i;
  end

  // size register clamp
  always_comb begin
    cfg_ext = 32'(cfg_wdata_i);
    if (cfg_ext == 32'd0) begin
      size_clamp = 32'd1;
    end else if (cfg_ext > MaxElements) begin
      size_clamp = MaxElements;
    end else begin
      size_clamp = cfg_ext;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR:     if (clr_q == NodeAw'(NodeCnt - 1)) state_d = ST_IDLE;
      ST_IDLE:    if (in_acc) state_d = ST_TOP;
      ST_TOP: begin
        if (sp_q == '0) begin
          if (!is_query_q || fin_ok) state_d = ST_IDLE;
        end else begin
          unique case (top_f.phase)
            arut_pkg::PH_ENTER: state_d = ST_RD_NODE;
            arut_pkg::PH_RIGHT: state_d = ST_TOP;
            arut_pkg::PH_CLOSE: state_d = is_query_q ? ST_TOP : ST_P2_L;
            default:            state_d = ST_TOP;
          endcase
        end
      end
      ST_RD_NODE: state_d = is_ident ? ST_DECIDE : ST_APPLY;
      ST_APPLY:   state_d = is_leaf ? ST_ND_S : ST_CH_RD;
      ST_DECIDE:  state_d = (covered && !is_query_q) ? ST_APPLY : ST_TOP;
      ST_CH_RD:   state_d = ST_CH_GET;
      ST_CH_GET:  state_d = ST_MWAIT;
      ST_CH_A:    state_d = ST_MWAIT;
      ST_CH_M:    state_d = ch_sel_q ? ST_ND_S : ST_CH_RD;
      ST_ND_S:    state_d = ST_MWAIT;
      ST_ND_A:    state_d = ST_MWAIT;
      ST_ND_W:    state_d = ret_pop_q ? ST_TOP : ST_DECIDE;
      ST_MWAIT:   if (mul_rsp_i.done) state_d = mul_next_q;
      ST_P2_L:    state_d = ST_P2_R;
      ST_P2_R:    state_d = ST_TOP;
      default:    state_d = ST_IDLE;
    endcase
    if (cfg_we_i) state_d = ST_CLR;
  end

  // node store port
  always_comb begin
    mem_we_o    = 1'b0;
    mem_addr_o  = top_f.node;
    mem_wdata_o = arut_pkg::ENTRY_CLEAR;
    unique case (state_q)
      ST_CLR: begin
        mem_we_o   = 1'b1;
        mem_addr_o = clr_q;
      end
      ST_TOP:   if (top_f.phase == arut_pkg::PH_CLOSE) mem_addr_o = lc;
      ST_CH_RD: mem_addr_o = ch_addr;
      ST_CH_M: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = ch_addr;
        mem_wdata_o = '{sum: ch_sum_q, mult: mul_rsp_i.p, add: ch_add_q};
      end
      ST_ND_W: begin
        mem_we_o        = 1'b1;
        mem_wdata_o.sum = tmp_q + mul_rsp_i.p;
      end
      ST_P2_L:  mem_addr_o = rc;
      ST_P2_R: begin
        mem_we_o        = 1'b1;
        mem_wdata_o.sum = tmp_q + mem_rdata_i.sum;
      end
      default: ;
    endcase
  end

  // multiplier requests
  always_comb begin
    mul_req_o = '{start: 1'b0, x: tm_q, y: tm_q};
    unique case (state_q)
      ST_CH_GET: mul_req_o = '{start: 1'b1, x: mem_rdata_i.add, y: tm_q};
      ST_CH_A:   mul_req_o = '{start: 1'b1, x: ch_mult_q, y: tm_q};
      ST_ND_S:   mul_req_o = '{start: 1'b1, x: nd_sum_q, y: tm_q};
      ST_ND_A:   mul_req_o = '{start: 1'b1, x: ta_q, y: 64'(len)};
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      size_q      <= SzW'(SizeRst);
      sp_q        <= '0;
      out_valid_q <= 1'b0;
      mul_next_q  <= ST_IDLE;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLR:   clr_q <= clr_q + 1'b1;
        ST_IDLE:  if (in_acc) sp_q <= (StkAw + 1)'(1);
        ST_TOP: begin
          if (sp_q == '0) begin
            if (is_query_q && fin_ok) out_valid_q <= 1'b1;
          end else if (top_f.phase == arut_pkg::PH_RIGHT) begin
            sp_q <= sp_q + 1'b1;
          end else if (top_f.phase == arut_pkg::PH_CLOSE && is_query_q) begin
            sp_q <= sp_q - 1'b1;
          end
        end
        ST_DECIDE: begin
          if (covered) begin
            if (is_query_q) sp_q <= sp_q - 1'b1;
          end else if (disjoint || is_leaf) begin
            sp_q <= sp_q - 1'b1;
          end else begin
            sp_q <= sp_q + 1'b1;
          end
        end
        ST_CH_GET: mul_next_q <= ST_CH_A;
        ST_CH_A:   mul_next_q <= ST_CH_M;
        ST_ND_S:   mul_next_q <= ST_ND_A;
        ST_ND_A:   mul_next_q <= ST_ND_W;
        ST_ND_W:   if (ret_pop_q) sp_q <= sp_q - 1'b1;
        ST_P2_R:   sp_q <= sp_q - 1'b1;
        default: ;
      endcase
      if (cfg_we_i) begin
        size_q <= SzW'(size_clamp);
        clr_q  <= '0;
      end
    end
  end

  // walk datapath and frame stack
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          is_query_q <= (opcode_i == arut_pkg::OP_QUERY);
          ql_q       <= left_index_i;
          qr_q       <= right_index_i;
          m_q        <= mult_factor_i;
          a_q        <= add_term_i;
          acc_q      <= 64'd0;
          stk_q[0]   <= '{node: '0, lo: '0, hi: IdxW'(size_q - 1'b1),
                          phase: arut_pkg::PH_ENTER};
        end
      end
      ST_TOP: begin
        if (sp_q == '0) begin
          if (is_query_q && fin_ok) out_sum_q <= acc_q;
        end else if (top_f.phase == arut_pkg::PH_RIGHT) begin
          stk_q[top_idx].phase <= arut_pkg::PH_CLOSE;
          stk_q[push_idx] <= '{node: rc, lo: mid + 1'b1, hi: top_f.hi,
                                phase: arut_pkg::PH_ENTER};
        end
      end
      ST_RD_NODE: begin
        nd_sum_q  <= mem_rdata_i.sum;
        tm_q      <= mem_rdata_i.mult;
        ta_q      <= mem_rdata_i.add;
        ret_pop_q <= 1'b0;
      end
      ST_APPLY: ch_sel_q <= 1'b0;
      ST_DECIDE: begin
        if (covered) begin
          if (is_query_q) begin
            acc_q <= acc_q + nd_sum_q;
          end else begin
            tm_q      <= m_q;
            ta_q      <= a_q;
            ret_pop_q <= 1'b1;
          end
        end else if (!(disjoint || is_leaf)) begin
          stk_q[top_idx].phase <= arut_pkg::PH_RIGHT;
          stk_q[push_idx] <= '{node: lc, lo: top_f.lo, hi: mid,
                                phase: arut_pkg::PH_ENTER};
        end
      end
      ST_CH_GET: begin
        ch_sum_q  <= mem_rdata_i.sum;
        ch_mult_q <= mem_rdata_i.mult;
      end
      ST_CH_A:  ch_add_q <= mul_rsp_i.p + ta_q;
      ST_CH_M:  ch_sel_q <= 1'b1;
      ST_ND_A:  tmp_q <= mul_rsp_i.p;
      ST_ND_W:  nd_sum_q <= tmp_q + mul_rsp_i.p;
      ST_P2_L:  tmp_q <= mem_rdata_i.sum;
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_sum_o   = out_sum_q;

endmodule

`default_nettype wire

### hw/rtl/arut_checker.sv
// ----------------------------------------------------------------------------
// arut_checker
// port-level checks of the tree block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "affine_range_update_sum_tree_defines.svh"

module arut_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_we_i,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [63:0] range_sum_o
);

  // a pending result holds until taken
  `ARUT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")
  `ARUT_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(range_sum_o), "result changed")
  // one transaction at a time
  `ARUT_ASSERT(a_busy_after_acc, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "ready after accept")
  // a size write starts the clearing pass
  `ARUT_ASSERT(a_clear_after_cfg, clk_i, rst_ni, cfg_we_i |=> !in_ready_o, "ready during clear")

endmodule

bind affine_range_update_sum_tree arut_checker u_arut_checker (.*);

`default_nettype wire

### bench/tb_affine_range_update_sum_tree.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_affine_range_update_sum_tree
// self-checking bench for the range-affine / range-sum tree: random and
// directed updates and queries, several tree sizes, predicted sums checked
// in order against every returned transaction
// ----------------------------------------------------------------------------
`default_nettype none

module tb_affine_range_update_sum_tree;

  localparam int NODES = 4096;

  typedef struct {
    logic        op;
    logic [9:0]  lidx;
    logic [9:0]  ridx;
    logic [63:0] mul;
    logic [63:0] add;
  } tree_op_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic opcode_i = arut_pkg::OP_UPDATE;
  logic [9:0] left_index_i = '0;
  logic [9:0] right_index_i = '0;
  logic signed [63:0] mult_factor_i = '0;
  logic signed [63:0] add_term_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [63:0] range_sum_o;

  affine_range_update_sum_tree u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .left_index_i  (left_index_i),
    .right_index_i (right_index_i),
    .mult_factor_i (mult_factor_i),
    .add_term_i    (add_term_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .range_sum_o   (range_sum_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow tree state
  logic [63:0] node_total[NODES];
  logic [63:0] node_mul[NODES];
  logic [63:0] node_add[NODES];
  int          tree_size = 1024;

  tree_op_t    pending_q[$];
  logic [63:0] sum_expected[$];
  int          err_count = 0;
  int          rx_hold = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic void tree_clear();
    for (int i = 0; i < NODES; i++) begin
      node_total[i] = '0;
      node_mul[i] = 64'd1;
      node_add[i] = '0;
    end
  endfunction

  // append an affine tag after the one a node already holds
  function automatic void tree_compose(int node, logic [63:0] m, logic [63:0] a);
    if (node >= NODES) return;
    node_add[node] = node_add[node] * m + a;
    node_mul[node] = node_mul[node] * m;
  endfunction

  // apply the pending tag to the node sum and pass it down
  function automatic void tree_push(int node, int lo, int hi);
    logic [63:0] m, a;
    if (node >= NODES) return;
    m = node_mul[node];
    a = node_add[node];
    if (m == 64'd1 && a == 64'd0) return;
    if (lo != hi) begin
      tree_compose(2 * node + 1, m, a);
      tree_compose(2 * node + 2, m, a);
    end
    node_total[node] = node_total[node] * m + a * 64'(hi - lo + 1);
    node_mul[node] = 64'd1;
    node_add[node] = '0;
  endfunction

  function automatic logic [63:0] node_value(int node);
    return (node < NODES) ? node_total[node] : 64'd0;
  endfunction

  function automatic void tree_walk(bit upd, int ql, int qr, logic [63:0] m, logic [63:0] a,
                                    int node, int lo, int hi, inout logic [63:0] acc);
    int mid;
    mid = (lo + hi) >> 1;
    tree_push(node, lo, hi);
    if (ql <= lo && hi <= qr) begin
      if (upd) begin
        tree_compose(node, m, a);
        tree_push(node, lo, hi);
      end else begin
        acc += node_value(node);
      end
    end else if (!(ql > hi || lo > qr || lo == hi)) begin
      tree_walk(upd, ql, qr, m, a, 2 * node + 1, lo, mid, acc);
      tree_walk(upd, ql, qr, m, a, 2 * node + 2, mid + 1, hi, acc);
      if (upd && node < NODES) node_total[node] = node_value(2 * node + 1) + node_value(2 * node + 2);
    end
  endfunction

  // random transaction, mostly inside the tree with small factors
  function automatic tree_op_t rand_op(int sz);
    tree_op_t t;
    t.op = ($urandom_range(0, 2) == 0) ? arut_pkg::OP_QUERY : arut_pkg::OP_UPDATE;
    if ($urandom_range(0, 9) < 8) begin
      t.lidx = 10'($urandom_range(0, sz - 1));
      t.ridx = 10'($urandom_range(t.lidx, sz - 1));
    end else begin
      t.lidx = 10'($urandom);
      t.ridx = 10'($urandom);
    end
    if ($urandom_range(0, 4) == 0) t.mul = {$urandom, $urandom};
    else t.mul = 64'(signed'($urandom_range(0, 6)) - 3);
    if ($urandom_range(0, 2) == 0) t.add = {$urandom, $urandom};
    else t.add = 64'(signed'($urandom_range(0, 2000)) - 1000);
    return t;
  endfunction

  function automatic tree_op_t mk_op(logic op, int l, int r, logic [63:0] m, logic [63:0] a);
    tree_op_t t;
    t.op = op;
    t.lidx = 10'(l);
    t.ridx = 10'(r);
    t.mul = m;
    t.add = a;
    return t;
  endfunction

  // wait for the block to drain, including trailing update walks
  task automatic settle();
    wait (pending_q.size() == 0 && !in_valid_i && sum_expected.size() == 0);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic set_size(input int v);
    settle();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = 11'(v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tree_size = (v < 1) ? 1 : ((v > 1024) ? 1024 : v);
    tree_clear();
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) pending_q.push_back(rand_op(tree_size));
  endtask

  // input acceptance and prediction
  always @(posedge clk_i) begin
    logic [63:0] acc;
    if (rst_ni && in_valid_i && in_ready_o) begin
      acc = '0;
      if (opcode_i == arut_pkg::OP_QUERY) begin
        tree_walk(1'b0, left_index_i, right_index_i, 64'd1, 64'd0, 0, 0, tree_size - 1, acc);
        sum_expected.push_back(acc);
      end else begin
        tree_walk(1'b1, left_index_i, right_index_i, mult_factor_i, add_term_i,
                  0, 0, tree_size - 1, acc);
      end
      in_fire = 1'b1;
    end
  end

  // input driver
  always @(negedge clk_i) begin
    tree_op_t t;
    if (in_fire) begin
      in_fire = 1'b0;
      in_valid_i = 1'b0;
      tx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    end
    if (!in_valid_i) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (pending_q.size() > 0) begin
        t = pending_q.pop_front();
        opcode_i = t.op;
        left_index_i = t.lidx;
        right_index_i = t.ridx;
        mult_factor_i = t.mul;
        add_term_i = t.add;
        in_valid_i = 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    logic [63:0] exp_sum;
    if (rst_ni && out_valid_o && out_ready_i) begin
      out_fire = 1'b1;
      if (sum_expected.size() == 0) begin
        report($sformatf("unexpected result range_sum=%0d", range_sum_o));
      end else begin
        exp_sum = sum_expected.pop_front();
        if (range_sum_o !== exp_sum)
          report($sformatf("range_sum got %0d expected %0d", range_sum_o, signed'(exp_sum)));
      end
    end
  end

  // result receiver with random stalls and the long hold-off
  always @(negedge clk_i) begin
    if (out_fire) begin
      out_fire = 1'b0;
      rx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i = 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // watchdog
  initial begin
    #(300_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus sequence
  initial begin
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    tree_clear();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed checks at the reset size
    pending_q.push_back(mk_op(arut_pkg::OP_QUERY, 0, 1023, 64'd0, 64'd0));
    pending_q.push_back(mk_op(arut_pkg::OP_UPDATE, 0, 1023, 64'd1, 64'd5));
    pending_q.push_back(mk_op(arut_pkg::OP_QUERY, 0, 1023, 64'd0, 64'd0));
    pending_q.push_back(mk_op(arut_pkg::OP_QUERY, 0, 0, 64'd0, 64'd0));
    pending_q.push_back(mk_op(arut_pkg::OP_QUERY, 1023, 1023, 64'd0, 64'd0));
    pending_q.push_back(mk_op(arut_pkg::OP_UPDATE, 10, 20, S64_MAX, S64_MIN));
    pending_q.push_back(mk_op(arut_pkg::OP_QUERY, 5, 25, S64_MAX, S64_MAX));
    pending_q.push_back(mk_op(arut_pkg::OP_UPDATE, 300, 300, 64'd0, S64_MAX));
    pending_q.push_back(mk_op(arut_pkg::OP_QUERY, 300, 300, 64'd0, 64'd0));
    pending_q.push_back(mk_op(arut_pkg::OP_UPDATE, 500, 400, 64'd3, 64'd9));
    pending_q.push_back(mk_op(arut_pkg::OP_QUERY, 500, 400, 64'd0, 64'd0));
    pending_q.push_back(mk_op(arut_pkg::OP_UPDATE, 0, 1023, S64_MIN, -64'sd1));
    pending_q.push_back(mk_op(arut_pkg::OP_QUERY, 0, 1023, 64'd0, 64'd0));
    pending_q.push_back(mk_op(arut_pkg::OP_UPDATE, 0, 511, -64'sd1, 64'd0));
    pending_q.push_back(mk_op(arut_pkg::OP_QUERY, 256, 767, 64'd0, 64'd0));
    pending_q.push_back(mk_op(arut_pkg::OP_QUERY, 1023, 0, 64'd0, 64'd0));

    // long receiver hold-off while queries keep coming
    settle();
    rx_hold = 400;
    for (int i = 0; i < 20; i++)
      pending_q.push_back(mk_op(arut_pkg::OP_QUERY, i, 1000 - i, 64'd0, 64'd0));
    add_random(480);

    // small tree; ranges beyond the size get clipped or dropped
    set_size(1);
    pending_q.push_back(mk_op(arut_pkg::OP_UPDATE, 0, 1023, 64'd2, 64'd7));
    pending_q.push_back(mk_op(arut_pkg::OP_QUERY, 0, 1023, 64'd0, 64'd0));
    pending_q.push_back(mk_op(arut_pkg::OP_UPDATE, 1, 1023, 64'd0, 64'd9));
    pending_q.push_back(mk_op(arut_pkg::OP_QUERY, 5, 1023, 64'd0, 64'd0));
    pending_q.push_back(mk_op(arut_pkg::OP_QUERY, 0, 0, 64'd0, 64'd0));
    add_random(95);

    // zero size counts as one
    set_size(0);
    add_random(60);

    // sender pauses mid phase until every result is back
    set_size(2);
    add_random(50);
    settle();
    add_random(50);

    set_size(7);
    add_random(150);

    // oversize write counts as the full tree
    set_size(2047);
    pending_q.push_back(mk_op(arut_pkg::OP_UPDATE, 0, 1023, 64'd1, 64'd1));
    pending_q.push_back(mk_op(arut_pkg::OP_QUERY, 0, 1023, 64'd0, 64'd0));
    add_random(300);

    set_size(37);
    add_random(200);

    set_size(300);
    add_random(200);

    set_size(1024);
    add_random(40);

    settle();
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

### affine_range_update_sum_tree.f
+incdir+hw/rtl
hw/rtl/arut_pkg.sv
hw/rtl/arut_mul.sv
hw/rtl/arut_node_ram.sv
hw/rtl/arut_ctrl.sv
hw/rtl/affine_range_update_sum_tree.sv
hw/rtl/arut_checker.sv
bench/tb_affine_range_update_sum_tree.sv
